// ===== src/nzcv_pkg.sv =====
// ----------------------------------------------------------------------------
// nzcv_pkg
// Shared constants, opcodes and helpers of the nzcv execute unit.
// ----------------------------------------------------------------------------
package nzcv_pkg;

   // sizes (data depth is a power of two)
   localparam int DATA_DEPTH = 1024;
   localparam int PC_BITS    = 16;
   localparam int REG_COUNT  = 256;
   localparam int REG_BITS   = $clog2(REG_COUNT);
   localparam int DADDR_BITS = $clog2(DATA_DEPTH);
   localparam int WORD_BITS  = 32;

   // opcodes
   localparam logic [7:0] OP_HALT     = 8'd0;
   localparam logic [7:0] OP_ADD      = 8'd1;
   localparam logic [7:0] OP_SUB      = 8'd2;
   localparam logic [7:0] OP_MUL      = 8'd3;
   localparam logic [7:0] OP_DIV      = 8'd4;
   localparam logic [7:0] OP_LD_REG   = 8'd5;
   localparam logic [7:0] OP_ST_REG   = 8'd6;
   localparam logic [7:0] OP_MOV      = 8'd7;
   localparam logic [7:0] OP_ADDI     = 8'd9;
   localparam logic [7:0] OP_SUBI     = 8'd10;
   localparam logic [7:0] OP_MULI     = 8'd11;
   localparam logic [7:0] OP_DIVI     = 8'd12;
   localparam logic [7:0] OP_LD_CON   = 8'd13;
   localparam logic [7:0] OP_ST_CON   = 8'd14;
   localparam logic [7:0] OP_MOVI     = 8'd15;
   localparam logic [7:0] OP_BR_FIRST = 8'd16;
   localparam logic [7:0] OP_BR_LAST  = 8'd30;

   // condition codes
   localparam logic [3:0] CC_EQ = 4'd0;
   localparam logic [3:0] CC_NE = 4'd1;
   localparam logic [3:0] CC_CS = 4'd2;
   localparam logic [3:0] CC_CC = 4'd3;
   localparam logic [3:0] CC_MI = 4'd4;
   localparam logic [3:0] CC_PL = 4'd5;
   localparam logic [3:0] CC_VS = 4'd6;
   localparam logic [3:0] CC_VC = 4'd7;
   localparam logic [3:0] CC_HI = 4'd8;
   localparam logic [3:0] CC_LS = 4'd9;
   localparam logic [3:0] CC_GE = 4'd10;
   localparam logic [3:0] CC_LT = 4'd11;
   localparam logic [3:0] CC_GT = 4'd12;
   localparam logic [3:0] CC_LE = 4'd13;

   // divider request
   typedef struct packed {
      logic                 start;
      logic [WORD_BITS-1:0] dividend;
      logic [WORD_BITS-1:0] divisor;
   } div_req_type;

   // divider reply
   typedef struct packed {
      logic                 done;
      logic [WORD_BITS-1:0] quotient;
   } div_rsp_type;

   // condition check against packed nzcv
   function automatic logic cond_holds(input logic [3:0] code, input logic [3:0] f);
      logic n, z, c, v, r;
      n = f[3];
      z = f[2];
      c = f[1];
      v = f[0];
      case (code)
         CC_EQ:   r = z;
         CC_NE:   r = !z;
         CC_CS:   r = c;
         CC_CC:   r = !c;
         CC_MI:   r = n;
         CC_PL:   r = !n;
         CC_VS:   r = v;
         CC_VC:   r = !v;
         CC_HI:   r = c && !z;
         CC_LS:   r = !c || z;
         CC_GE:   r = (n == v);
         CC_LT:   r = (n != v);
         CC_GT:   r = !z && (n == v);
         CC_LE:   r = z || (n != v);
         default: r = 1'b1;
      endcase
      return r;
   endfunction

endpackage

// ===== src/nzcv_if.sv =====
// ----------------------------------------------------------------------------
// nzcv channel interfaces
// Instruction and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nzcv_req_if;
   logic              valid;
   logic              ready;
   logic [7:0]        operation;
   logic [7:0]        dest_field;
   logic [7:0]        src1_field;
   logic signed [7:0] src2_field;

   modport source (output valid, operation, dest_field, src1_field, src2_field,
                   input ready);
   modport sink   (input valid, operation, dest_field, src1_field, src2_field,
                   output ready);
endinterface

interface nzcv_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        next_pc;
   logic               halted;
   logic [3:0]         flags_nzcv;
   logic               reg_written;
   logic signed [31:0] written_value;
   logic               branch_taken;

   modport source (output valid, next_pc, halted, flags_nzcv, reg_written,
                   written_value, branch_taken, input ready);
   modport sink   (input valid, next_pc, halted, flags_nzcv, reg_written,
                   written_value, branch_taken, output ready);
endinterface

// ===== src/nzcv_ram.sv =====
// ----------------------------------------------------------------------------
// nzcv_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module nzcv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== src/nzcv_div.sv =====
// ----------------------------------------------------------------------------
// nzcv_div
// Signed 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nzcv_div (
   input  logic                 clock,
   input  logic                 reset,
   input  nzcv_pkg::div_req_type req,
   output nzcv_pkg::div_rsp_type rsp
);

   localparam int W = nzcv_pkg::WORD_BITS;

   logic                 busy_ff;
   logic                 done_ff;
   logic                 neg_ff;
   logic [$clog2(W)-1:0] cnt_ff;
   logic [W:0]           rem_ff;
   logic [W-1:0]         quo_ff;
   logic [W-1:0]         den_ff;
   logic [W:0]           shifted;
   logic [W:0]           trial;

   // one restoring step
   assign shifted = {rem_ff[W-1:0], quo_ff[W-1]};
   assign trial   = shifted - {1'b0, den_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == $clog2(W)'(W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath on magnitudes
   always_ff @(posedge clock) begin
      if (req.start) begin
         neg_ff <= req.dividend[W-1] ^ req.divisor[W-1];
         rem_ff <= '0;
         quo_ff <= req.dividend[W-1] ? (W'(0) - req.dividend) : req.dividend;
         den_ff <= req.divisor[W-1] ? (W'(0) - req.divisor) : req.divisor;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted;
            quo_ff <= {quo_ff[W-2:0], 1'b0};
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = neg_ff ? (W'(0) - quo_ff) : quo_ff;

endmodule

// ===== src/nzcv_register_cpu_execute_unit.sv =====
// ----------------------------------------------------------------------------
// nzcv_register_cpu_execute_unit
// Execute stage of a small load/store processor with NZCV flags. Registers
// and data bytes live in synchronous RAMs; each instruction reads its
// operands, executes and writes back before the next one is taken.
//
//   channel  dir  beat payload
//   req      in   operation, dest_field, src1_field, src2_field
//   rsp      out  next_pc, halted, flags_nzcv, reg_written, written_value,
//                 branch_taken
//
// An instruction steps through ST_RD_A, ST_RD_B, ST_RD_D, ST_CAP_D, ST_EXEC
// and ST_FIN, adding ST_LOAD for a load and ST_DIV for a nonzero divisor;
// its rsp beat is registered in ST_FIN. The three operand reads on the single
// register RAM port and the one-bit-per-cycle divider set this sequence; a
// beat taken while halted goes straight to ST_FIN. After reset the data RAM
// is cleared, one byte per cycle, before the first beat is taken. The result
// register frees the next accept; a stalled rsp holds writeback.
// ----------------------------------------------------------------------------
module nzcv_register_cpu_execute_unit (
   input  logic        clock,
   input  logic        reset,
   nzcv_req_if.sink    req_chan,
   nzcv_rsp_if.source  rsp_chan
);

   localparam int RB = nzcv_pkg::REG_BITS;
   localparam int DB = nzcv_pkg::DADDR_BITS;
   localparam int PB = nzcv_pkg::PC_BITS;
   localparam int W  = nzcv_pkg::WORD_BITS;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_A, ST_RD_B, ST_RD_D, ST_CAP_D, ST_EXEC, ST_DIV, ST_LOAD, ST_FIN
   } state_type;

   state_type state_ff;

   // latched instruction
   logic [7:0]    op_ff;
   logic [7:0]    d_ff;
   logic [7:0]    s1_ff;
   logic [7:0]    s2_ff;

   // architectural state
   logic [PB-1:0]        pc_ff;
   logic [3:0]           flags_ff;
   logic                 halt_ff;

   logic [nzcv_pkg::REG_COUNT-1:0] rvalid_ff;

   // operands and result
   logic [W-1:0] a_ff;
   logic [W-1:0] b_ff;
   logic [W-1:0] rd_ff;
   logic [W-1:0] val_ff;
   logic         wr_ff;
   logic         taken_ff;
   logic         skip_ff;

   // clearing pass
   logic          clr_busy_ff;
   logic [DB-1:0] clr_idx_ff;

   // output register
   logic               out_valid_ff;
   logic [15:0]        out_pc_ff;
   logic               out_halt_ff;
   logic [3:0]         out_flags_ff;
   logic               out_wr_ff;
   logic [W-1:0]       out_val_ff;
   logic               out_taken_ff;

   // ram ports
   logic          rf_we;
   logic [RB-1:0] rf_raddr;
   logic [W-1:0]  rf_rdata;
   logic          rf_rvld_ff;
   logic [W-1:0]  rf_val;
   logic          dm_we;
   logic [DB-1:0] dm_waddr;
   logic [7:0]    dm_wdata;
   logic [DB-1:0] dm_raddr;
   logic [7:0]    dm_rdata;

   nzcv_pkg::div_req_type div_req;
   nzcv_pkg::div_rsp_type div_rsp;

   // decode helpers
   logic [W-1:0]  imm;
   logic [W-1:0]  opb;
   logic          imm_form;
   logic [W:0]    add_sum;
   logic [W-1:0]  sub_dif;
   logic [W-1:0]  mul_prod;
   logic [PB-1:0] pc_seq;
   logic [PB-1:0] pc_br;
   logic          slot_free;

   assign imm      = {{(W-8){s2_ff[7]}}, s2_ff};
   assign imm_form = op_ff[3];
   assign opb      = imm_form ? imm : b_ff;
   assign add_sum  = {1'b0, a_ff} + {1'b0, opb};
   assign sub_dif  = a_ff - opb;
   assign mul_prod = a_ff * opb;
   assign pc_seq   = pc_ff + PB'(4);
   assign pc_br    = pc_ff + {imm[PB-3:0], 2'b00};
   assign slot_free = !out_valid_ff || rsp_chan.ready;

   // register file
   always_comb begin
      case (state_ff)
         ST_RD_B: rf_raddr = s2_ff[RB-1:0];
         ST_RD_D: rf_raddr = d_ff[RB-1:0];
         default: rf_raddr = s1_ff[RB-1:0];
      endcase
   end

   assign rf_we  = (state_ff == ST_FIN) && slot_free && wr_ff && !skip_ff;
   assign rf_val = rf_rvld_ff ? rf_rdata : '0;

   nzcv_ram #(.WIDTH(W), .DEPTH(nzcv_pkg::REG_COUNT)) u_regs (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (d_ff[RB-1:0]),
      .wr_data (val_ff),
      .rd_addr (rf_raddr),
      .rd_data (rf_rdata)
   );

   // data memory ports, clearing pass takes the write port
   always_comb begin
      dm_we    = 1'b0;
      dm_waddr = clr_idx_ff;
      dm_wdata = 8'd0;
      if (clr_busy_ff) begin
         dm_we = 1'b1;
      end else if (state_ff == ST_EXEC && op_ff == nzcv_pkg::OP_ST_REG) begin
         dm_we    = 1'b1;
         dm_waddr = rd_ff[DB-1:0];
         dm_wdata = a_ff[7:0];
      end else if (state_ff == ST_EXEC && op_ff == nzcv_pkg::OP_ST_CON) begin
         dm_we    = 1'b1;
         dm_waddr = DB'(d_ff);
         dm_wdata = a_ff[7:0];
      end
      dm_raddr = (op_ff == nzcv_pkg::OP_LD_REG) ? a_ff[DB-1:0] : DB'(s1_ff);
   end

   nzcv_ram #(.WIDTH(8), .DEPTH(nzcv_pkg::DATA_DEPTH)) u_data (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_addr (dm_raddr),
      .rd_data (dm_rdata)
   );

   // divider
   assign div_req.start    = (state_ff == ST_EXEC) && (opb != '0) &&
                             (op_ff == nzcv_pkg::OP_DIV || op_ff == nzcv_pkg::OP_DIVI);
   assign div_req.dividend = a_ff;
   assign div_req.divisor  = opb;

   nzcv_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // handshake
   assign req_chan.ready = (state_ff == ST_IDLE) && !clr_busy_ff;

   // sequencer, state and result registers
   always_ff @(posedge clock) begin
      rf_rvld_ff <= rvalid_ff[rf_raddr];
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         flags_ff     <= '0;
         halt_ff      <= 1'b0;
         rvalid_ff    <= '0;
         clr_busy_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         // clearing pass
         if (clr_busy_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == DB'(nzcv_pkg::DATA_DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (out_valid_ff && rsp_chan.ready && !(state_ff == ST_FIN && slot_free)) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid && req_chan.ready) begin
                  op_ff    <= req_chan.operation;
                  d_ff     <= req_chan.dest_field;
                  s1_ff    <= req_chan.src1_field;
                  s2_ff    <= req_chan.src2_field;
                  wr_ff    <= 1'b0;
                  taken_ff <= 1'b0;
                  val_ff   <= '0;
                  skip_ff  <= halt_ff;
                  state_ff <= halt_ff ? ST_FIN : ST_RD_A;
               end
            end
            ST_RD_A: state_ff <= ST_RD_B;
            ST_RD_B: begin
               a_ff     <= rf_val;
               state_ff <= ST_RD_D;
            end
            ST_RD_D: begin
               b_ff     <= rf_val;
               state_ff <= ST_CAP_D;
            end
            ST_CAP_D: begin
               rd_ff    <= rf_val;
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               state_ff <= ST_FIN;
               case (op_ff)
                  nzcv_pkg::OP_HALT: halt_ff <= 1'b1;
                  nzcv_pkg::OP_ADD, nzcv_pkg::OP_ADDI: begin
                     val_ff   <= add_sum[W-1:0];
                     wr_ff    <= 1'b1;
                     flags_ff <= {add_sum[W-1], add_sum[W-1:0] == '0, add_sum[W],
                                  ~(a_ff[W-1] ^ opb[W-1]) & (a_ff[W-1] ^ add_sum[W-1])};
                  end
                  nzcv_pkg::OP_SUB, nzcv_pkg::OP_SUBI: begin
                     val_ff   <= sub_dif;
                     wr_ff    <= 1'b1;
                     flags_ff <= {sub_dif[W-1], sub_dif == '0, a_ff >= opb,
                                  (a_ff[W-1] ^ opb[W-1]) & (a_ff[W-1] ^ sub_dif[W-1])};
                  end
                  nzcv_pkg::OP_MUL, nzcv_pkg::OP_MULI: begin
                     val_ff <= mul_prod;
                     wr_ff  <= 1'b1;
                  end
                  nzcv_pkg::OP_DIV, nzcv_pkg::OP_DIVI: begin
                     if (opb != '0) begin
                        state_ff <= ST_DIV;
                     end
                  end
                  nzcv_pkg::OP_LD_REG, nzcv_pkg::OP_LD_CON: state_ff <= ST_LOAD;
                  nzcv_pkg::OP_MOV, nzcv_pkg::OP_MOVI: begin
                     val_ff <= W'(s1_ff);
                     wr_ff  <= 1'b1;
                  end
                  default: begin
                     if (op_ff inside {[nzcv_pkg::OP_BR_FIRST:nzcv_pkg::OP_BR_LAST]}) begin
                        taken_ff <= nzcv_pkg::cond_holds(4'(op_ff - nzcv_pkg::OP_BR_FIRST),
                                                         flags_ff);
                     end
                  end
               endcase
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  val_ff   <= div_rsp.quotient;
                  wr_ff    <= 1'b1;
                  state_ff <= ST_FIN;
               end
            end
            ST_LOAD: begin
               val_ff   <= {{(W-8){dm_rdata[7]}}, dm_rdata};
               wr_ff    <= 1'b1;
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (slot_free) begin
                  out_valid_ff <= 1'b1;
                  out_halt_ff  <= halt_ff;
                  out_flags_ff <= flags_ff;
                  out_wr_ff    <= wr_ff && !skip_ff;
                  out_val_ff   <= skip_ff ? '0 : val_ff;
                  out_taken_ff <= taken_ff && !skip_ff;
                  if (skip_ff) begin
                     out_pc_ff <= 16'(pc_ff);
                  end else begin
                     pc_ff     <= taken_ff ? pc_br : pc_seq;
                     out_pc_ff <= 16'(taken_ff ? pc_br : pc_seq);
                  end
                  if (rf_we) begin
                     rvalid_ff[d_ff[RB-1:0]] <= 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // result channel
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.next_pc       = out_pc_ff;
   assign rsp_chan.halted        = out_halt_ff;
   assign rsp_chan.flags_nzcv    = out_flags_ff;
   assign rsp_chan.reg_written   = out_wr_ff;
   assign rsp_chan.written_value = out_val_ff;
   assign rsp_chan.branch_taken  = out_taken_ff;

endmodule

// ===== verif/nzcv_register_cpu_execute_unit_tb.sv =====
// ----------------------------------------------------------------------------
// nzcv_register_cpu_execute_unit_tb
// Self-checking bench for the execute unit. A table of directed instructions
// is followed by random instruction streams; every rsp beat is compared
// against a behavioral model of the register file, flags, pc, halt and data
// memory, with random idling on both channels.
// ----------------------------------------------------------------------------
module nzcv_register_cpu_execute_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_PCT    = 38;
   localparam int RANDOM_BEATS = 1030;
   localparam int STALL_LIMIT = 20000;
   localparam int PCB         = nzcv_pkg::PC_BITS;
   localparam int DAB         = nzcv_pkg::DADDR_BITS;

   typedef struct packed {
      logic [7:0]        op;
      logic [7:0]        dst;
      logic [7:0]        s1;
      logic signed [7:0] s2;
   } instr_type;

   typedef struct packed {
      logic [15:0]        pc;
      logic               halted;
      logic [3:0]         nzcv;
      logic               wr;
      logic signed [31:0] value;
      logic               taken;
   } outcome_type;

   // a directed row; has_fixed marks an outcome typed in by hand
   typedef struct {
      instr_type   ins;
      logic        has_fixed;
      outcome_type fixed;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nzcv_req_if req_chan ();
   nzcv_rsp_if rsp_chan ();

   nzcv_register_cpu_execute_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // machine state mirror
   logic [31:0]   cpu_regs [nzcv_pkg::REG_COUNT] = '{default: '0};
   logic [7:0]    cpu_mem  [nzcv_pkg::DATA_DEPTH] = '{default: '0};
   logic [PCB-1:0] cpu_pc    = '0;
   logic [3:0]    cpu_flags = '0;
   logic          cpu_halt  = 1'b0;

   outcome_type expected_q [$];
   instr_type   issue_q [$];
   int          failures = 0;
   int          fixed_failures = 0;
   int          stall_cycles = 0;
   logic        calm = 1'b0;

   function automatic logic [3:0] add_nzcv(logic [31:0] a, logic [31:0] b, logic [31:0] r);
      return {r[31], r == 0, r < a, (~(a[31] ^ b[31])) & (a[31] ^ r[31])};
   endfunction

   function automatic logic [3:0] sub_nzcv(logic [31:0] a, logic [31:0] b, logic [31:0] r);
      return {r[31], r == 0, a >= b, (a[31] ^ b[31]) & (a[31] ^ r[31])};
   endfunction

   function automatic logic [31:0] signed_quotient(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q  = ma / mb;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic logic branch_cond(logic [3:0] code, logic [3:0] f);
      logic n, z, c, v;
      {n, z, c, v} = f;
      case (code)
         nzcv_pkg::CC_EQ: return z;
         nzcv_pkg::CC_NE: return !z;
         nzcv_pkg::CC_CS: return c;
         nzcv_pkg::CC_CC: return !c;
         nzcv_pkg::CC_MI: return n;
         nzcv_pkg::CC_PL: return !n;
         nzcv_pkg::CC_VS: return v;
         nzcv_pkg::CC_VC: return !v;
         nzcv_pkg::CC_HI: return c && !z;
         nzcv_pkg::CC_LS: return !c || z;
         nzcv_pkg::CC_GE: return n == v;
         nzcv_pkg::CC_LT: return n != v;
         nzcv_pkg::CC_GT: return !z && (n == v);
         nzcv_pkg::CC_LE: return z || (n != v);
         default:         return 1'b1;
      endcase
   endfunction

   // execute one instruction on the mirror and return its outcome
   function automatic outcome_type execute_instr(instr_type ins);
      outcome_type o;
      logic [31:0] a, rb, imm, val;
      logic wr, tk;
      logic [PCB-1:0] old_pc;
      o = '0;
      wr = 1'b0;
      tk = 1'b0;
      val = '0;
      if (!cpu_halt) begin
         old_pc = cpu_pc;
         a = cpu_regs[ins.s1];
         rb = cpu_regs[ins.s2[7:0]];
         imm = {{24{ins.s2[7]}}, ins.s2};
         cpu_pc = PCB'(old_pc + PCB'(4));
         case (ins.op)
            nzcv_pkg::OP_HALT: cpu_halt = 1'b1;
            nzcv_pkg::OP_ADD: begin
               val = a + rb; cpu_flags = add_nzcv(a, rb, val); wr = 1'b1;
            end
            nzcv_pkg::OP_ADDI: begin
               val = a + imm; cpu_flags = add_nzcv(a, imm, val); wr = 1'b1;
            end
            nzcv_pkg::OP_SUB: begin
               val = a - rb; cpu_flags = sub_nzcv(a, rb, val); wr = 1'b1;
            end
            nzcv_pkg::OP_SUBI: begin
               val = a - imm; cpu_flags = sub_nzcv(a, imm, val); wr = 1'b1;
            end
            nzcv_pkg::OP_MUL:  begin val = a * rb;  wr = 1'b1; end
            nzcv_pkg::OP_MULI: begin val = a * imm; wr = 1'b1; end
            nzcv_pkg::OP_DIV: if (rb != 0) begin
               val = signed_quotient(a, rb); wr = 1'b1;
            end
            nzcv_pkg::OP_DIVI: if (imm != 0) begin
               val = signed_quotient(a, imm); wr = 1'b1;
            end
            nzcv_pkg::OP_LD_REG: begin
               val = {{24{cpu_mem[a[DAB-1:0]][7]}}, cpu_mem[a[DAB-1:0]]};
               wr = 1'b1;
            end
            nzcv_pkg::OP_LD_CON: begin
               val = {{24{cpu_mem[DAB'(ins.s1)][7]}}, cpu_mem[DAB'(ins.s1)]};
               wr = 1'b1;
            end
            nzcv_pkg::OP_ST_REG: cpu_mem[cpu_regs[ins.dst][DAB-1:0]] = a[7:0];
            nzcv_pkg::OP_ST_CON: cpu_mem[DAB'(ins.dst)] = a[7:0];
            nzcv_pkg::OP_MOV, nzcv_pkg::OP_MOVI: begin
               val = {24'd0, ins.s1}; wr = 1'b1;
            end
            default: if (ins.op >= nzcv_pkg::OP_BR_FIRST && ins.op <= nzcv_pkg::OP_BR_LAST) begin
               tk = branch_cond(4'(ins.op - nzcv_pkg::OP_BR_FIRST), cpu_flags);
               if (tk) cpu_pc = PCB'(old_pc + PCB'(imm << 2));
            end
         endcase
         if (wr) cpu_regs[ins.dst] = val;
      end
      o.pc = 16'(cpu_pc);
      o.halted = cpu_halt;
      o.nzcv = cpu_flags;
      o.wr = wr;
      o.value = wr ? val : '0;
      o.taken = tk;
      return o;
   endfunction

   function automatic instr_type mk(logic [7:0] op, logic [7:0] d, logic [7:0] s1,
                                    logic [7:0] s2);
      instr_type i;
      i.op = op; i.dst = d; i.s1 = s1; i.s2 = s2;
      return i;
   endfunction

   function automatic logic [7:0] random_op();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return 8'($urandom_range(1, 15));
      if (pick < 90) return 8'($urandom_range(nzcv_pkg::OP_BR_FIRST, nzcv_pkg::OP_BR_LAST));
      return 8'($urandom_range(31, 255));
   endfunction

   // directed table
   row_type directed [$];
   initial begin
      row_type r;
      outcome_type f;
      r.has_fixed = 1'b0;
      r.fixed = '0;
      // after reset: move extremes
      r.ins = mk(nzcv_pkg::OP_MOVI, 8'd1, 8'd255, 8'd0);
      f = '0; f.pc = 16'd4; f.wr = 1'b1; f.value = 32'd255;
      r.has_fixed = 1'b1; r.fixed = f; directed.push_back(r);
      r.ins = mk(nzcv_pkg::OP_MOV, 8'd255, 8'd0, 8'd0);
      f = '0; f.pc = 16'd8; f.wr = 1'b1; f.value = 32'd0;
      r.fixed = f; directed.push_back(r);
      // division by zero on a zero register writes nothing
      r.ins = mk(nzcv_pkg::OP_DIV, 8'd2, 8'd1, 8'd0);
      f = '0; f.pc = 16'd12;
      r.fixed = f; directed.push_back(r);
      r.has_fixed = 1'b0;
      r.ins = mk(nzcv_pkg::OP_DIVI, 8'd2, 8'd1, 8'd0); directed.push_back(r);
      // build 0xF0000000 in r3 then divide by -1
      r.ins = mk(nzcv_pkg::OP_ADDI, 8'd3, 8'd0, 8'sh80); directed.push_back(r);
      r.ins = mk(nzcv_pkg::OP_MULI, 8'd3, 8'd3, 8'sh80); directed.push_back(r);
      r.ins = mk(nzcv_pkg::OP_MULI, 8'd3, 8'd3, 8'sh80); directed.push_back(r);
      r.ins = mk(nzcv_pkg::OP_MULI, 8'd3, 8'd3, 8'sh80); directed.push_back(r);
      r.ins = mk(nzcv_pkg::OP_MULI, 8'd3, 8'd3, 8'sh7f); directed.push_back(r);
      r.ins = mk(nzcv_pkg::OP_DIVI, 8'd4, 8'd3, 8'shff); directed.push_back(r);
      r.ins = mk(nzcv_pkg::OP_SUBI, 8'd5, 8'd3, 8'd1);   directed.push_back(r);
      r.ins = mk(nzcv_pkg::OP_ADD, 8'd6, 8'd3, 8'd3);    directed.push_back(r);
      r.ins = mk(nzcv_pkg::OP_SUB, 8'd7, 8'd1, 8'd1);    directed.push_back(r);
      r.ins = mk(nzcv_pkg::OP_MUL, 8'd8, 8'd1, 8'd255);  directed.push_back(r);
      r.ins = mk(nzcv_pkg::OP_DIV, 8'd9, 8'd3, 8'd1);    directed.push_back(r);
      // stores and loads, register and constant address, wrap
      r.ins = mk(nzcv_pkg::OP_ST_CON, 8'd255, 8'd1, 8'd0);  directed.push_back(r);
      r.ins = mk(nzcv_pkg::OP_LD_CON, 8'd10, 8'd255, 8'd0); directed.push_back(r);
      r.ins = mk(nzcv_pkg::OP_ST_REG, 8'd3, 8'd1, 8'd0);    directed.push_back(r);
      r.ins = mk(nzcv_pkg::OP_LD_REG, 8'd11, 8'd3, 8'd0);   directed.push_back(r);
      // unused opcodes and branches
      r.ins = mk(8'd8, 8'd0, 8'd0, 8'd0);      directed.push_back(r);
      r.ins = mk(8'd255, 8'd0, 8'd0, 8'd0);    directed.push_back(r);
      r.ins = mk(nzcv_pkg::OP_BR_FIRST, 8'd0, 8'd0, 8'sh7f); directed.push_back(r);
      r.ins = mk(nzcv_pkg::OP_BR_LAST, 8'd0, 8'd0, 8'sh80);  directed.push_back(r);
      r.ins = mk(8'd17, 8'd0, 8'd0, 8'sh01);   directed.push_back(r);
   end

   // accepted instructions feed the model
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         issue_q.push_back(mk(req_chan.operation, req_chan.dest_field,
                              req_chan.src1_field, req_chan.src2_field));
      end
   end

   // rsp scoreboard
   always @(posedge clock) begin
      outcome_type got, want;
      instr_type ins;
      while (issue_q.size() > 0) begin
         ins = issue_q.pop_front();
         expected_q.push_back(execute_instr(ins));
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.pc = rsp_chan.next_pc;
         got.halted = rsp_chan.halted;
         got.nzcv = rsp_chan.flags_nzcv;
         got.wr = rsp_chan.reg_written;
         got.value = rsp_chan.written_value;
         got.taken = rsp_chan.branch_taken;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected rsp beat, expected none, actual %p", $time, got);
            failures++;
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               $display("%0t: rsp mismatch, expected %p, actual %p", $time, want, got);
               failures++;
            end
         end
      end
   end

   // fixed outcomes in the directed table, checked at the rsp side too
   outcome_type fixed_q [$];
   logic        fixed_on [$];
   always @(posedge clock) begin
      outcome_type f;
      logic on;
      if (!reset && rsp_chan.valid && rsp_chan.ready && fixed_on.size() > 0) begin
         on = fixed_on.pop_front();
         f = fixed_q.pop_front();
         if (on && (rsp_chan.next_pc !== f.pc || rsp_chan.reg_written !== f.wr ||
                    rsp_chan.written_value !== f.value || rsp_chan.halted !== f.halted ||
                    rsp_chan.flags_nzcv !== f.nzcv || rsp_chan.branch_taken !== f.taken)) begin
            $display("%0t: directed mismatch, expected %p, actual pc %h val %h", $time,
                     f, rsp_chan.next_pc, rsp_chan.written_value);
            fixed_failures++;
         end
      end
   end

   // rsp ready with random stalls
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("nzcv_register_cpu_execute_unit regression: fail");
            $finish;
         end
      end
   end

   task automatic send_instr(instr_type ins);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.operation  <= ins.op;
      req_chan.dest_field <= ins.dst;
      req_chan.src1_field <= ins.s1;
      req_chan.src2_field <= ins.s2;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   initial begin
      instr_type ins;
      int sent;
      req_chan.valid = 1'b0;
      req_chan.operation = '0;
      req_chan.dest_field = '0;
      req_chan.src1_field = '0;
      req_chan.src2_field = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      foreach (directed[i]) begin
         fixed_on.push_back(directed[i].has_fixed);
         fixed_q.push_back(directed[i].fixed);
         send_instr(directed[i].ins);
      end

      // random streams: mostly ALU, load, store and move ops on a few registers, halt near the end
      sent = 0;
      while (sent < RANDOM_BEATS) begin
         calm = (sent >= 300 && sent < 400);
         ins.op  = random_op();
         ins.dst = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
         ins.s1  = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
         ins.s2  = ($urandom_range(1) == 0) ? 8'($urandom) : 8'($urandom_range(15));
         if (sent == RANDOM_BEATS - 20) ins.op = nzcv_pkg::OP_HALT;
         fixed_on.push_back(1'b0);
         fixed_q.push_back('0);
         send_instr(ins);
         sent++;
      end
      calm = 1'b0;
      req_chan.valid <= 1'b0;

      while (expected_q.size() > 0 || issue_q.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (failures == 0 && fixed_failures == 0 && expected_q.size() == 0)
         $display("nzcv_register_cpu_execute_unit regression: pass");
      else
         $display("nzcv_register_cpu_execute_unit regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/nzcv_pkg.sv
src/nzcv_if.sv
src/nzcv_ram.sv
src/nzcv_div.sv
src/nzcv_register_cpu_execute_unit.sv
verif/nzcv_register_cpu_execute_unit_tb.sv
